>>> rtl/core/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

   // Built server count and the widths that follow from it
   localparam int MAX_SERVERS = 32;
   localparam int IDX_W       = $clog2(MAX_SERVERS);
   localparam int NEFF_W      = IDX_W + 1;

   // Field widths
   localparam int NSRV_W = 6;
   localparam int TIME_W = 31;
   localparam int BUSY_W = 32;
   localparam int CNT_W  = 32;
   localparam int SID_W  = 5;

   localparam logic [NSRV_W-1:0] NSRV_RESET = NSRV_W'(32);

   // Input action codes
   localparam logic ACT_DISPATCH = 1'b0;
   localparam logic ACT_REPORT   = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // latch arrival and load time
      logic scan;        // register the free-server mask
      logic dsp_commit;  // assign server, update state, write result
      logic best_clear;  // restart the maximum search
      logic max_step;    // fold the indexed count into the maximum
      logic idx_clear;
      logic idx_advance;
      logic rpt_emit;    // write a report entry for the indexed server
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic idx_end;     // index is at the last server in use
      logic match;       // indexed count equals the maximum
      logic last_match;  // indexed server is the last one at the maximum
   } sts_type;

   // Clamp the configured count to 1..MAX_SERVERS
   function automatic logic [NEFF_W-1:0] servers_in_use(input logic [NSRV_W-1:0] v);
      logic [NEFF_W-1:0] n;
      if (v == '0) begin
         n = NEFF_W'(1);
      end else if (int'(v) > MAX_SERVERS) begin
         n = NEFF_W'(MAX_SERVERS);
      end else begin
         n = NEFF_W'(v);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rotating_server_dispatcher_core.sv
// Rotating server dispatcher: spreads timed requests over the servers in use.
// Input channel req_*: action 0 dispatches a request at req_arrival_time that
// keeps a server busy for req_load_time; action 1 asks for a report of the
// busiest servers. Result channel rsp_*: one entry per dispatch (server id, or
// dropped when no server is free), one entry per busiest server for a report,
// rsp_last set on the final entry of each item. csr_we/csr_wdata set the
// number of servers in use; write it only while the block is idle.
// Sequencing: one item is worked on at a time. A dispatch registers the
// free-server mask (free-mask compare), then makes the rotated pick and
// update, which writes the result; the input opens again as it is written.
// A report sweeps the counts once for the maximum and once more to emit,
// one server a cycle (a busiest server only once the result register is
// free), stopping at the last busiest server.
// Reset: every server free, all counts zero, start position zero, 32 servers
// in use. When the receiver stalls, the result register holds; the next item
// is still taken and worked on, and its result waits for the register.
`default_nettype none

module rotating_server_dispatcher_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_action,
   input  wire logic [rsd_pkg::TIME_W-1:0] req_arrival_time,
   input  wire logic [rsd_pkg::TIME_W-1:0] req_load_time,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_is_report,
   output logic [rsd_pkg::SID_W-1:0]       rsp_server_id,
   output logic                            rsp_dropped,
   output logic                            rsp_last,
   input  wire logic                       csr_we,
   input  wire logic [rsd_pkg::NSRV_W-1:0] csr_wdata
);

   rsd_pkg::cmd_type cmd;
   rsd_pkg::sts_type sts;

   // Sequence each item
   rsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Server state, search and result register
   rsd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_arrival_time (req_arrival_time),
      .req_load_time    (req_load_time),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_is_report    (rsp_is_report),
      .rsp_server_id    (rsp_server_id),
      .rsp_dropped      (rsp_dropped),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // One item at a time: a transfer closes the input until the item is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in progress");

   // A new result is written only into a free result register
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.dsp_commit || cmd.rpt_emit) |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before transfer");

   // Commands that move the item along are exclusive
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.dsp_commit, cmd.rpt_emit, cmd.max_step}))
      else $error("conflicting datapath commands");

   // A dispatch result is always the final entry and reports never drop
   a_dispatch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_is_report && rsp_last) || (rsp_is_report && !rsp_dropped)))
      else $error("malformed result entry");
`endif

endmodule

`default_nettype wire

>>> rtl/core/rsd_ctrl.sv
`default_nettype none

module rsd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output rsd_pkg::cmd_type      cmd,
   input  wire rsd_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      IDLE,
      DSP_SCAN,
      DSP_COMMIT,
      RPT_MAX,
      RPT_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      emit;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequence the item and issue datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      emit     = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req_action == rsd_pkg::ACT_REPORT) begin
                  cmd.best_clear = 1'b1;
                  cmd.idx_clear  = 1'b1;
                  state_in       = RPT_MAX;
               end else begin
                  cmd.load = 1'b1;
                  state_in = DSP_SCAN;
               end
            end
         end
         DSP_SCAN: begin
            cmd.scan = 1'b1;
            state_in = DSP_COMMIT;
         end
         DSP_COMMIT: begin
            if (out_free) begin
               cmd.dsp_commit = 1'b1;
               emit           = 1'b1;
               state_in       = IDLE;
            end
         end
         RPT_MAX: begin
            cmd.max_step = 1'b1;
            if (sts.idx_end) begin
               cmd.idx_clear = 1'b1;
               state_in      = RPT_EMIT;
            end else begin
               cmd.idx_advance = 1'b1;
            end
         end
         RPT_EMIT: begin
            if (!sts.match) begin
               cmd.idx_advance = 1'b1;
            end else if (out_free) begin
               cmd.rpt_emit    = 1'b1;
               cmd.idx_advance = 1'b1;
               emit            = 1'b1;
               if (sts.last_match) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Raise valid on a new result, drop it after the transfer
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/rsd_datapath.sv
`default_nettype none

module rsd_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [rsd_pkg::NSRV_W-1:0]          csr_wdata,
   input  wire logic [rsd_pkg::TIME_W-1:0]          req_arrival_time,
   input  wire logic [rsd_pkg::TIME_W-1:0]          req_load_time,
   input  wire rsd_pkg::cmd_type                    cmd,
   output rsd_pkg::sts_type                         sts,
   output logic                                     rsp_is_report,
   output logic [rsd_pkg::SID_W-1:0]                rsp_server_id,
   output logic                                     rsp_dropped,
   output logic                                     rsp_last
);

   localparam int NS = rsd_pkg::MAX_SERVERS;

   // Per-server state
   logic [rsd_pkg::BUSY_W-1:0] busy_ff  [NS];
   logic [rsd_pkg::BUSY_W-1:0] busy_in  [NS];
   logic [rsd_pkg::CNT_W-1:0]  count_ff [NS];
   logic [rsd_pkg::CNT_W-1:0]  count_in [NS];

   logic [rsd_pkg::IDX_W-1:0]  start_ff, start_in;
   logic [rsd_pkg::NSRV_W-1:0] nsrv_ff;
   logic [rsd_pkg::TIME_W-1:0] time_ff, load_ff;
   logic [NS-1:0]              free_ff, free_in;
   logic [rsd_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [rsd_pkg::CNT_W-1:0]  best_ff, best_in;
   logic [rsd_pkg::IDX_W-1:0]  lastidx_ff, lastidx_in;

   logic                       is_report_ff, dropped_ff, last_ff;
   logic [rsd_pkg::IDX_W-1:0]  sid_ff;

   logic [rsd_pkg::NEFF_W-1:0] n_eff;
   logic [rsd_pkg::IDX_W-1:0]  start_eff;
   logic [rsd_pkg::NEFF_W-1:0] start_inc;
   logic [NS-1:0]              hi_mask;
   logic [rsd_pkg::IDX_W-1:0]  hi_pick, any_pick, chosen;
   logic                       found;
   logic [rsd_pkg::BUSY_W-1:0] busy_new;
   logic [rsd_pkg::CNT_W-1:0]  ch_cnt, ch_cnt_inc;
   logic [rsd_pkg::CNT_W-1:0]  cnt_sel;

   assign n_eff     = rsd_pkg::servers_in_use(nsrv_ff);
   assign start_eff = ({1'b0, start_ff} < n_eff) ? start_ff : '0;
   assign start_inc = {1'b0, start_eff} + rsd_pkg::NEFF_W'(1);
   assign start_in  = (start_inc >= n_eff) ? '0 : start_inc[rsd_pkg::IDX_W-1:0];

   // Mark servers in use whose busy time has passed
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         free_in[i] = (busy_ff[i] <= {1'b0, time_ff}) &&
                      (rsd_pkg::NEFF_W'(i) < n_eff);
      end
   end

   // Pick the first free server at or above the start, else the first free one
   always_comb begin
      hi_pick  = '0;
      any_pick = '0;
      for (int i = 0; i < NS; i++) begin
         hi_mask[i] = free_ff[i] && (rsd_pkg::IDX_W'(i) >= start_eff);
      end
      for (int i = NS - 1; i >= 0; i--) begin
         if (hi_mask[i]) begin
            hi_pick = rsd_pkg::IDX_W'(i);
         end
         if (free_ff[i]) begin
            any_pick = rsd_pkg::IDX_W'(i);
         end
      end
   end

   assign found      = |free_ff;
   assign chosen     = (|hi_mask) ? hi_pick : any_pick;
   assign busy_new   = rsd_pkg::BUSY_W'(time_ff) + rsd_pkg::BUSY_W'(load_ff);
   assign ch_cnt     = count_ff[chosen];
   assign ch_cnt_inc = (ch_cnt == '1) ? ch_cnt : ch_cnt + rsd_pkg::CNT_W'(1);

   // Update the chosen server on commit
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         busy_in[i]  = busy_ff[i];
         count_in[i] = count_ff[i];
      end
      if (cmd.dsp_commit && found) begin
         busy_in[chosen]  = busy_new;
         count_in[chosen] = ch_cnt_inc;
      end
   end

   // Report sweep: track the maximum and the last server holding it
   assign cnt_sel = count_ff[idx_ff];

   always_comb begin
      best_in    = best_ff;
      lastidx_in = lastidx_ff;
      if (cmd.best_clear) begin
         best_in = '0;
      end else if (cmd.max_step && (cnt_sel >= best_ff)) begin
         best_in    = cnt_sel;
         lastidx_in = idx_ff;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_advance) begin
         idx_in = idx_ff + rsd_pkg::IDX_W'(1);
      end
   end

   assign sts.idx_end    = ({1'b0, idx_ff} == (n_eff - rsd_pkg::NEFF_W'(1)));
   assign sts.match      = (cnt_sel == best_ff);
   assign sts.last_match = (idx_ff == lastidx_ff);

   // Hold server state, start position and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '{default: '0};
         count_ff <= '{default: '0};
         start_ff <= '0;
         nsrv_ff  <= rsd_pkg::NSRV_RESET;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         if (cmd.dsp_commit) begin
            start_ff <= start_in;
         end
         if (csr_we) begin
            nsrv_ff <= csr_wdata;
         end
      end
   end

   // Working registers and the result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_arrival_time;
         load_ff <= req_load_time;
      end
      if (cmd.scan) begin
         free_ff <= free_in;
      end
      idx_ff     <= idx_in;
      best_ff    <= best_in;
      lastidx_ff <= lastidx_in;
      if (cmd.dsp_commit) begin
         is_report_ff <= 1'b0;
         sid_ff       <= found ? chosen : '0;
         dropped_ff   <= !found;
         last_ff      <= 1'b1;
      end else if (cmd.rpt_emit) begin
         is_report_ff <= 1'b1;
         sid_ff       <= idx_ff;
         dropped_ff   <= 1'b0;
         last_ff      <= sts.last_match;
      end
   end

   assign rsp_is_report = is_report_ff;
   assign rsp_server_id = rsd_pkg::SID_W'(sid_ff);
   assign rsp_dropped   = dropped_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

>>> tb/rotating_server_dispatcher_core_tb.sv
`timescale 1ns / 1ps

module rotating_server_dispatcher_core_tb;

   localparam int LIMIT  = 1_000_000;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 40;
   localparam int PHASE_N [PHASES] = '{1, 2, 3, 5, 8, 32, 17, 0, 63, 31, 4, 33};

   typedef struct packed {
      logic                      is_report;
      logic [rsd_pkg::SID_W-1:0] server_id;
      logic                      dropped;
      logic                      last;
   } result_type;

   typedef struct {
      bit                         wr_cfg;     // write the server count before this item
      logic [rsd_pkg::NSRV_W-1:0] cfg_val;
      logic                       action;
      logic [rsd_pkg::TIME_W-1:0] arrival;
      logic [rsd_pkg::TIME_W-1:0] load;
      bit                         typed;      // result given in the row, single entry
      logic [rsd_pkg::SID_W-1:0]  exp_id;
      logic                       exp_drop;
   } step_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_action = rsd_pkg::ACT_DISPATCH;
   logic [rsd_pkg::TIME_W-1:0]   req_arrival_time = '0;
   logic [rsd_pkg::TIME_W-1:0]   req_load_time = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_is_report;
   logic [rsd_pkg::SID_W-1:0]    rsp_server_id;
   logic                         rsp_dropped;
   logic                         rsp_last;
   logic                         csr_we = 1'b0;
   logic [rsd_pkg::NSRV_W-1:0]   csr_wdata = '0;

   // Shadow of the dispatcher state
   logic [rsd_pkg::BUSY_W-1:0]   srv_busy_until [rsd_pkg::MAX_SERVERS];
   logic [rsd_pkg::CNT_W-1:0]    srv_handled [rsd_pkg::MAX_SERVERS];
   int                           rr_start = 0;
   logic [rsd_pkg::NSRV_W-1:0]   num_servers_q = rsd_pkg::NSRV_RESET;

   result_type                   assignments_due [$];
   step_type                     plan [$];
   int                           err_count = 0;
   int                           cycle_count = 0;
   bit                           tx_idle = 1'b1;
   bit                           rx_idle = 1'b1;

   rotating_server_dispatcher_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_arrival_time (req_arrival_time),
      .req_load_time    (req_load_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_report    (rsp_is_report),
      .rsp_server_id    (rsp_server_id),
      .rsp_dropped      (rsp_dropped),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("[rotating_server_dispatcher_core] ERROR");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      err_count++;
      if (err_count <= 100) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Clamp the configured count to the servers that take part
   function automatic int in_use(input logic [rsd_pkg::NSRV_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > rsd_pkg::MAX_SERVERS) begin
         return rsd_pkg::MAX_SERVERS;
      end
      return int'(v);
   endfunction

   // Advance the shadow state by one item and queue the entries it causes
   function automatic void dispatch_step(input logic action,
                                         input logic [rsd_pkg::TIME_W-1:0] at,
                                         input logic [rsd_pkg::TIME_W-1:0] ld,
                                         input bit record);
      int                         n;
      int                         start;
      int                         pos;
      int                         chosen;
      int                         last_top;
      bit                         found;
      logic [rsd_pkg::BUSY_W-1:0] now;
      logic [rsd_pkg::CNT_W-1:0]  top;
      result_type                 r;
      n = in_use(num_servers_q);
      if (action == rsd_pkg::ACT_REPORT) begin
         // rank: every server at the top count, ascending, last one flagged
         top = '0;
         last_top = 0;
         for (int i = 0; i < n; i++) begin
            if (srv_handled[i] > top) begin
               top = srv_handled[i];
            end
         end
         for (int i = 0; i < n; i++) begin
            if (srv_handled[i] == top) begin
               last_top = i;
            end
         end
         for (int i = 0; i < n; i++) begin
            if (srv_handled[i] == top) begin
               r.is_report = 1'b1;
               r.server_id = rsd_pkg::SID_W'(i);
               r.dropped   = 1'b0;
               r.last      = (i == last_top);
               if (record) begin
                  assignments_due.push_back(r);
               end
            end
         end
      end else begin
         // search from the rotating start for the first free server
         now = {1'b0, at};
         start = (rr_start < n) ? rr_start : 0;
         pos = start;
         found = 1'b0;
         chosen = 0;
         for (int i = 0; i < n && !found; i++) begin
            if (srv_busy_until[pos] <= now) begin
               found = 1'b1;
               chosen = pos;
            end else begin
               pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
         end
         if (found) begin
            srv_busy_until[chosen] = now + {1'b0, ld};
            if (srv_handled[chosen] != '1) begin
               srv_handled[chosen] = srv_handled[chosen] + 1'b1;
            end
         end
         rr_start = (start + 1 >= n) ? 0 : start + 1;
         r.is_report = 1'b0;
         r.server_id = found ? rsd_pkg::SID_W'(chosen) : rsd_pkg::SID_W'(0);
         r.dropped   = !found;
         r.last      = 1'b1;
         if (record) begin
            assignments_due.push_back(r);
         end
      end
   endfunction

   function automatic void plan_row(input bit wr, input logic [rsd_pkg::NSRV_W-1:0] v,
                                    input logic act,
                                    input logic [rsd_pkg::TIME_W-1:0] at,
                                    input logic [rsd_pkg::TIME_W-1:0] ld, input bit typed,
                                    input logic [rsd_pkg::SID_W-1:0] id, input logic drop);
      step_type s;
      s.wr_cfg   = wr;
      s.cfg_val  = v;
      s.action   = act;
      s.arrival  = at;
      s.load     = ld;
      s.typed    = typed;
      s.exp_id   = id;
      s.exp_drop = drop;
      plan.push_back(s);
   endfunction

   // Write the server count once every owed entry is back and the core is quiet
   task automatic write_servers(input logic [rsd_pkg::NSRV_W-1:0] v);
      req_valid <= 1'b0;
      while (assignments_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      num_servers_q = v;
   endtask

   task automatic send_item(input step_type s);
      int         gap;
      result_type r;
      gap = tx_idle ? $urandom_range(7, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= s.action;
      req_arrival_time <= s.arrival;
      req_load_time    <= s.load;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      // transfer taken at this edge
      if (s.typed) begin
         dispatch_step(s.action, s.arrival, s.load, 1'b0);
         r.is_report = s.action;
         r.server_id = s.exp_id;
         r.dropped   = s.exp_drop;
         r.last      = 1'b1;
         assignments_due.push_back(r);
      end else begin
         dispatch_step(s.action, s.arrival, s.load, 1'b1);
      end
   endtask

   // Result side: stall at random, check each transfer against the oldest entry
   initial begin
      int         gap;
      result_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(7, 0) : 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (assignments_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: report %b id %0d drop %b last %b",
                                    rsp_is_report, rsp_server_id, rsp_dropped, rsp_last));
         end else begin
            want = assignments_due.pop_front();
            if (rsp_is_report !== want.is_report) begin
               flag_mismatch($sformatf("is_report %b, want %b", rsp_is_report, want.is_report));
            end
            if (rsp_server_id !== want.server_id) begin
               flag_mismatch($sformatf("server_id %0d, want %0d", rsp_server_id,
                                       want.server_id));
            end
            if (rsp_dropped !== want.dropped) begin
               flag_mismatch($sformatf("dropped %b, want %b", rsp_dropped, want.dropped));
            end
            if (rsp_last !== want.last) begin
               flag_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
      end
   end

   initial begin
      step_type    it;
      int unsigned now_t;
      int          n_eff;
      int          roll;
      for (int i = 0; i < rsd_pkg::MAX_SERVERS; i++) begin
         srv_busy_until[i] = '0;
         srv_handled[i]    = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, 32 servers in use after reset
      plan_row(0, 0, rsd_pkg::ACT_REPORT, 0, 0, 0, 0, 0);              // all tied at zero
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 10, 5, 1, 0, 0);
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 10, 0, 1, 1, 0);
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 10, 0, 1, 2, 0);
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 10, 0, 1, 3, 0);
      // full-scale time and load: server 4 stays busy for good
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 4, 0);
      plan_row(0, 0, rsd_pkg::ACT_REPORT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0);
      // two servers, start left past the count: search from server 0
      plan_row(1, 2, rsd_pkg::ACT_DISPATCH, 12, 100, 1, 1, 0);
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 13, 0, 1, 0, 1);           // both busy
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 15, 7, 1, 0, 0);           // free right at busy-until
      plan_row(0, 0, rsd_pkg::ACT_DISPATCH, 3, 1, 1, 0, 1);            // time steps back
      plan_row(0, 0, rsd_pkg::ACT_REPORT, 0, 0, 0, 0, 0);
      // zero acts as one server
      plan_row(1, 0, rsd_pkg::ACT_DISPATCH, 30, 0, 1, 0, 0);
      plan_row(0, 0, rsd_pkg::ACT_REPORT, 0, 0, 1, 0, 0);
      // above the built count acts as all servers
      plan_row(1, 6'h3F, rsd_pkg::ACT_DISPATCH, 30, 0, 1, 0, 0);
      plan_row(0, 0, rsd_pkg::ACT_REPORT, 0, 0, 1, 0, 0);
      plan_row(1, 33, rsd_pkg::ACT_DISPATCH, 40, 9, 1, 2, 0);
      plan_row(1, 1, rsd_pkg::ACT_DISPATCH, 41, 0, 1, 0, 0);

      foreach (plan[i]) begin
         if (plan[i].wr_cfg) begin
            write_servers(plan[i].cfg_val);
         end
         send_item(plan[i]);
      end

      // Random phases, one server count each
      now_t = 100;
      it.wr_cfg   = 1'b0;
      it.cfg_val  = '0;
      it.typed    = 1'b0;
      it.exp_id   = '0;
      it.exp_drop = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         write_servers(rsd_pkg::NSRV_W'(PHASE_N[p]));
         n_eff = in_use(rsd_pkg::NSRV_W'(PHASE_N[p]));
         tx_idle = ($urandom_range(3, 0) != 0);
         rx_idle = ($urandom_range(3, 0) != 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(99, 0);
            if (roll < 12) begin
               // time fields are don't-care on a ranking request
               it.action  = rsd_pkg::ACT_REPORT;
               it.arrival = rsd_pkg::TIME_W'($urandom);
               it.load    = rsd_pkg::TIME_W'($urandom);
            end else begin
               // mostly rising time, with jumps high, restarts and steps back
               it.action = rsd_pkg::ACT_DISPATCH;
               if (roll < 15) begin
                  now_t = $urandom_range(32'h7FFF_FF00, 32'h4000_0000);
               end else if (roll < 19) begin
                  now_t = $urandom_range(1000, 0);
               end else if (roll < 22) begin
                  now_t = $urandom_range(now_t, 0);
               end else if (now_t < 32'h7FFF_FF00) begin
                  now_t = now_t + $urandom_range(12, 0);
               end
               it.arrival = rsd_pkg::TIME_W'(now_t);
               if (roll > 96 && now_t < 32'h0100_0000) begin
                  it.load = rsd_pkg::TIME_W'($urandom);
               end else begin
                  it.load = rsd_pkg::TIME_W'($urandom_range(8 * n_eff, 0));
               end
            end
            send_item(it);
         end
      end

      // Drain, then give the core time to show any stray entry
      req_valid <= 1'b0;
      while (assignments_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (err_count == 0) begin
         $display("[rotating_server_dispatcher_core] OK");
      end else begin
         $display("[rotating_server_dispatcher_core] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/rsd_pkg.sv
rtl/core/rsd_ctrl.sv
rtl/core/rsd_datapath.sv
rtl/core/rotating_server_dispatcher_core.sv
tb/rotating_server_dispatcher_core_tb.sv
